// ===== rtl/core/i2csdb_pkg.sv =====
// ============================================================================
// I2C slave double buffer - shared definitions
// Depths, derived widths, bus status codes, item kinds and the command
// word passed from the classifier through the queue to the executor.
// ============================================================================
package i2csdb_pkg;

    // Buffer depths and derived widths
    localparam int TX_DEPTH = 16;
    localparam int RX_DEPTH = 16;
    localparam int TX_IW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_IW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_PW    = $clog2(TX_DEPTH + 1);
    localparam int RX_PW    = $clog2(RX_DEPTH + 1);

    // Item kinds
    localparam logic [1:0] KIND_BUS   = 2'd0;
    localparam logic [1:0] KIND_TX_WR = 2'd1;
    localparam logic [1:0] KIND_RX_RD = 2'd2;

    // TWI status codes (low three bits masked off)
    localparam logic [7:0] STATUS_MASK      = 8'hF8;
    localparam logic [7:0] ST_SR_SLA_ACK    = 8'h60;
    localparam logic [7:0] ST_SR_ARB_SLA    = 8'h68;
    localparam logic [7:0] ST_SR_GCALL_ACK  = 8'h70;
    localparam logic [7:0] ST_SR_ARB_GCALL  = 8'h78;
    localparam logic [7:0] ST_SR_DATA_ACK   = 8'h80;
    localparam logic [7:0] ST_SR_DATA_NACK  = 8'h88;
    localparam logic [7:0] ST_SR_GDATA_ACK  = 8'h90;
    localparam logic [7:0] ST_SR_GDATA_NACK = 8'h98;
    localparam logic [7:0] ST_SR_STOP       = 8'hA0;
    localparam logic [7:0] ST_ST_SLA_ACK    = 8'hA8;
    localparam logic [7:0] ST_ST_ARB_SLA    = 8'hB0;
    localparam logic [7:0] ST_ST_DATA_ACK   = 8'hB8;
    localparam logic [7:0] ST_ST_DATA_NACK  = 8'hC0;
    localparam logic [7:0] ST_ST_LAST_ACK   = 8'hC8;
    localparam logic [7:0] ST_BUS_ERROR     = 8'h00;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RD_ADDR,
        OP_TX_DATA,
        OP_TX_END,
        OP_WR_ADDR,
        OP_RX_ACK,
        OP_RX_NACK,
        OP_STOP,
        OP_BUS_ERR,
        OP_USER_WR,
        OP_USER_RD
    } t_op;

    typedef logic [TX_IW-1:0] t_tx_idx;
    typedef logic [RX_IW-1:0] t_rx_idx;
    typedef logic [TX_PW-1:0] t_tx_pos;
    typedef logic [RX_PW-1:0] t_rx_pos;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;    // bus byte or user byte
        logic [3:0] index;
        logic       last;
        logic       idx_ok;  // index within the addressed buffer
    } t_cmd;

endpackage

// ===== rtl/core/i2c_slave_double_buffer.sv =====
// ============================================================================
// I2C slave double buffer - top level
// Buffer controller for an I2C slave: double-buffered transmit store and
// a receive store, driven by bus status events and user accesses.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_ready) carries one word per item: a bus
//   status event (TWI status code plus received byte), a user write into
//   the shadow transmit half, or a user read of the receive store.
//   Output channel (o_valid / i_ready) returns exactly one result word per
//   input word, in order: byte to send, ack enable after the item, data
//   ready flag before the item, and the byte read by the user.
//   A word accepted on the input is first registered in the command queue,
//   and its result is then registered in the output register.
//   Throughput: one word per cycle while results are taken, set by the
//   executor and the one-port-per-cycle use of each store.
//   Stall: the result sits in the output register; new words keep flowing
//   into the two-entry command queue, and o_ready drops once it is full.
//   Reset (i_rst_n low, synchronous): flags, positions, queue and output
//   register clear, ack enable comes up set, the first transmit half is
//   active. Store contents are undefined until written.
// ============================================================================
module i2c_slave_double_buffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_status_code,
    input  logic [7:0] i_bus_byte,
    input  logic [3:0] i_index,
    input  logic [7:0] i_user_byte,
    input  logic       i_last,
    // output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_ack_enable,
    output logic       o_data_ready,
    output logic [7:0] o_read_byte
);

    i2csdb_pkg::t_cmd w_front_cmd;
    i2csdb_pkg::t_cmd w_q_cmd;
    logic             w_push;
    logic             w_q_full;
    logic             w_q_valid;
    logic             w_pop;

    // classify incoming words
    i2csdb_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_status_code (i_status_code),
        .i_bus_byte    (i_bus_byte),
        .i_index       (i_index),
        .i_user_byte   (i_user_byte),
        .i_last        (i_last),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd)
    );

    // decouples acceptance from execution
    i2csdb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_cmd       (w_front_cmd),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_cmd_valid (w_q_valid),
        .o_cmd       (w_q_cmd)
    );

    // state, stores and output register
    i2csdb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_q_valid),
        .i_cmd        (w_q_cmd),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tx_byte    (o_tx_byte),
        .o_ack_enable (o_ack_enable),
        .o_data_ready (o_data_ready),
        .o_read_byte  (o_read_byte)
    );

endmodule

// ===== rtl/core/i2csdb_front.sv =====
// ============================================================================
// I2C slave double buffer - front classifier
// Decodes each incoming word into a command and pushes it into the queue.
// ============================================================================
module i2csdb_front (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_status_code,
    input  logic [7:0]        i_bus_byte,
    input  logic [3:0]        i_index,
    input  logic [7:0]        i_user_byte,
    input  logic              i_last,
    input  logic              i_q_full,
    output logic              o_push,
    output i2csdb_pkg::t_cmd  o_cmd
);

    logic [7:0] w_status;

    assign w_status = i_status_code & i2csdb_pkg::STATUS_MASK;
    assign o_ready  = !i_q_full;
    assign o_push   = i_valid && !i_q_full;

    always_comb begin
        o_cmd.op     = i2csdb_pkg::OP_NONE;
        o_cmd.data   = (i_kind == i2csdb_pkg::KIND_BUS) ? i_bus_byte : i_user_byte;
        o_cmd.index  = i_index;
        o_cmd.last   = i_last;
        o_cmd.idx_ok = 1'b0;
        unique case (i_kind)
            i2csdb_pkg::KIND_BUS: begin
                unique case (w_status) inside
                    i2csdb_pkg::ST_ST_SLA_ACK, i2csdb_pkg::ST_ST_ARB_SLA:
                        o_cmd.op = i2csdb_pkg::OP_RD_ADDR;
                    i2csdb_pkg::ST_ST_DATA_ACK:
                        o_cmd.op = i2csdb_pkg::OP_TX_DATA;
                    i2csdb_pkg::ST_ST_DATA_NACK, i2csdb_pkg::ST_ST_LAST_ACK:
                        o_cmd.op = i2csdb_pkg::OP_TX_END;
                    i2csdb_pkg::ST_SR_SLA_ACK, i2csdb_pkg::ST_SR_ARB_SLA,
                    i2csdb_pkg::ST_SR_GCALL_ACK, i2csdb_pkg::ST_SR_ARB_GCALL:
                        o_cmd.op = i2csdb_pkg::OP_WR_ADDR;
                    i2csdb_pkg::ST_SR_DATA_ACK, i2csdb_pkg::ST_SR_GDATA_ACK:
                        o_cmd.op = i2csdb_pkg::OP_RX_ACK;
                    i2csdb_pkg::ST_SR_DATA_NACK, i2csdb_pkg::ST_SR_GDATA_NACK:
                        o_cmd.op = i2csdb_pkg::OP_RX_NACK;
                    i2csdb_pkg::ST_SR_STOP:
                        o_cmd.op = i2csdb_pkg::OP_STOP;
                    i2csdb_pkg::ST_BUS_ERROR:
                        o_cmd.op = i2csdb_pkg::OP_BUS_ERR;
                    default:
                        o_cmd.op = i2csdb_pkg::OP_NONE;
                endcase
            end
            i2csdb_pkg::KIND_TX_WR: begin
                o_cmd.op     = i2csdb_pkg::OP_USER_WR;
                o_cmd.idx_ok = int'(i_index) < i2csdb_pkg::TX_DEPTH;
            end
            i2csdb_pkg::KIND_RX_RD: begin
                o_cmd.op     = i2csdb_pkg::OP_USER_RD;
                o_cmd.idx_ok = int'(i_index) < i2csdb_pkg::RX_DEPTH;
            end
            default: o_cmd.op = i2csdb_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/i2csdb_queue.sv =====
// ============================================================================
// I2C slave double buffer - command queue
// Two-entry FIFO between the classifier and the executor.
// ============================================================================
module i2csdb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  i2csdb_pkg::t_cmd  i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_cmd_valid,
    output i2csdb_pkg::t_cmd  o_cmd
);

    i2csdb_pkg::t_cmd r_entry [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) r_entry[r_wptr] <= i_cmd;
    end

endmodule

// ===== rtl/core/i2csdb_back.sv =====
// ============================================================================
// I2C slave double buffer - executor
// Holds the buffer state and both stores, carries out one command per cycle
// unless stalled, and keeps the result in an output register until taken.
// ============================================================================
module i2csdb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  i2csdb_pkg::t_cmd  i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_tx_byte,
    output logic              o_ack_enable,
    output logic              o_data_ready,
    output logic [7:0]        o_read_byte
);

    // stores, no reset
    logic [7:0] r_tx_mem [2][i2csdb_pkg::TX_DEPTH];
    logic [7:0] r_rx_mem [i2csdb_pkg::RX_DEPTH];

    // control state
    logic                r_half,   n_half;
    logic                r_swap,   n_swap;
    logic                r_busy,   n_busy;
    i2csdb_pkg::t_tx_pos r_tx_pos, n_tx_pos;
    i2csdb_pkg::t_rx_pos r_rx_pos, n_rx_pos;
    logic                r_ready,  n_ready;
    logic                r_ack,    n_ack;

    // output register
    logic       r_out_valid;
    logic       r_tx_sel;
    logic       r_rd_sel;
    logic       r_ack_q;
    logic       r_rdy_q;
    logic [7:0] r_tx_q;
    logic [7:0] r_rx_q;

    logic                w_adv;
    logic                w_is_send;
    logic                w_do_swap;
    logic                w_half_eff;
    i2csdb_pkg::t_tx_pos w_pos0;
    i2csdb_pkg::t_tx_pos w_pos_clamp;
    i2csdb_pkg::t_tx_pos w_pos1;
    i2csdb_pkg::t_tx_idx w_tx_rd_idx;
    logic                w_rx_room;
    i2csdb_pkg::t_rx_pos w_rx_inc;
    logic                w_rx_store;

    assign w_adv = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_pop = w_adv;

    assign w_is_send  = (i_cmd.op == i2csdb_pkg::OP_RD_ADDR) ||
                        (i_cmd.op == i2csdb_pkg::OP_TX_DATA);
    assign w_do_swap  = (i_cmd.op == i2csdb_pkg::OP_RD_ADDR) && r_swap && !r_busy;
    assign w_half_eff = r_half ^ w_do_swap;

    // address ack restarts at position zero; position saturates at depth
    assign w_pos0      = (i_cmd.op == i2csdb_pkg::OP_RD_ADDR) ? '0 : r_tx_pos;
    assign w_pos_clamp = (w_pos0 > i2csdb_pkg::TX_PW'(i2csdb_pkg::TX_DEPTH - 1)) ?
                         i2csdb_pkg::TX_PW'(i2csdb_pkg::TX_DEPTH - 1) : w_pos0;
    assign w_pos1      = (w_pos0 < i2csdb_pkg::TX_PW'(i2csdb_pkg::TX_DEPTH)) ?
                         w_pos0 + i2csdb_pkg::TX_PW'(1) : w_pos0;
    assign w_tx_rd_idx = i2csdb_pkg::t_tx_idx'(w_pos_clamp);

    assign w_rx_room  = r_rx_pos < i2csdb_pkg::RX_PW'(i2csdb_pkg::RX_DEPTH);
    assign w_rx_inc   = w_rx_room ? r_rx_pos + i2csdb_pkg::RX_PW'(1) : r_rx_pos;
    assign w_rx_store = ((i_cmd.op == i2csdb_pkg::OP_RX_ACK) ||
                         (i_cmd.op == i2csdb_pkg::OP_RX_NACK)) && w_rx_room;

    always_comb begin
        n_half   = r_half;
        n_swap   = r_swap;
        n_busy   = r_busy;
        n_tx_pos = r_tx_pos;
        n_rx_pos = r_rx_pos;
        n_ready  = r_ready;
        n_ack    = r_ack;
        if (w_adv) begin
            unique case (i_cmd.op) inside
                i2csdb_pkg::OP_RD_ADDR, i2csdb_pkg::OP_TX_DATA: begin
                    if (w_do_swap) begin
                        n_half = ~r_half;
                        n_swap = 1'b0;
                    end
                    n_tx_pos = w_pos1;
                    if (w_pos1 == i2csdb_pkg::TX_PW'(i2csdb_pkg::TX_DEPTH)) n_ack = 1'b0;
                end
                i2csdb_pkg::OP_TX_END, i2csdb_pkg::OP_BUS_ERR: begin
                    n_ack = 1'b1;
                end
                i2csdb_pkg::OP_WR_ADDR: begin
                    n_ready  = 1'b0;
                    n_rx_pos = '0;
                    if (i2csdb_pkg::RX_DEPTH == 1) n_ack = 1'b0;
                end
                i2csdb_pkg::OP_RX_ACK: begin
                    n_rx_pos = w_rx_inc;
                    // drop ack one byte before the buffer fills
                    if (w_rx_inc == i2csdb_pkg::RX_PW'(i2csdb_pkg::RX_DEPTH - 1)) n_ack = 1'b0;
                end
                i2csdb_pkg::OP_RX_NACK: begin
                    n_rx_pos = w_rx_inc;
                    n_ready  = 1'b1;
                end
                i2csdb_pkg::OP_STOP: begin
                    n_ready = 1'b1;
                end
                i2csdb_pkg::OP_USER_WR: begin
                    n_swap = 1'b1;
                    n_busy = !i_cmd.last;
                end
                i2csdb_pkg::OP_USER_RD: begin
                    if (i_cmd.last && r_ready) begin
                        n_ready = 1'b0;
                        n_ack   = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= 1'b0;
            r_swap      <= 1'b0;
            r_busy      <= 1'b0;
            r_tx_pos    <= '0;
            r_rx_pos    <= '0;
            r_ready     <= 1'b0;
            r_ack       <= 1'b1;
            r_out_valid <= 1'b0;
            r_tx_sel    <= 1'b0;
            r_rd_sel    <= 1'b0;
            r_ack_q     <= 1'b0;
            r_rdy_q     <= 1'b0;
        end else begin
            r_half   <= n_half;
            r_swap   <= n_swap;
            r_busy   <= n_busy;
            r_tx_pos <= n_tx_pos;
            r_rx_pos <= n_rx_pos;
            r_ready  <= n_ready;
            r_ack    <= n_ack;
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_tx_sel    <= w_is_send;
                r_rd_sel    <= (i_cmd.op == i2csdb_pkg::OP_USER_RD) && i_cmd.idx_ok;
                r_ack_q     <= n_ack;
                r_rdy_q     <= r_ready;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transmit store: user writes the shadow half, bus reads the active half
    always_ff @(posedge i_clk) begin
        if (w_adv && (i_cmd.op == i2csdb_pkg::OP_USER_WR) && i_cmd.idx_ok) begin
            r_tx_mem[~r_half][i2csdb_pkg::t_tx_idx'(i_cmd.index)] <= i_cmd.data;
        end
        if (w_adv && w_is_send) begin
            r_tx_q <= r_tx_mem[w_half_eff][w_tx_rd_idx];
        end
    end

    // receive store
    always_ff @(posedge i_clk) begin
        if (w_adv && w_rx_store) begin
            r_rx_mem[i2csdb_pkg::t_rx_idx'(r_rx_pos)] <= i_cmd.data;
        end
        if (w_adv && (i_cmd.op == i2csdb_pkg::OP_USER_RD) && i_cmd.idx_ok) begin
            r_rx_q <= r_rx_mem[i2csdb_pkg::t_rx_idx'(i_cmd.index)];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tx_byte    = r_tx_sel ? r_tx_q : 8'h00;
    assign o_read_byte  = r_rd_sel ? r_rx_q : 8'h00;
    assign o_ack_enable = r_ack_q;
    assign o_data_ready = r_rdy_q;

    a_tx_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_pos <= i2csdb_pkg::TX_PW'(i2csdb_pkg::TX_DEPTH))
        else $error("tx position past depth");

    a_rx_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_pos <= i2csdb_pkg::RX_PW'(i2csdb_pkg::RX_DEPTH))
        else $error("rx position past depth");

    a_read_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (i_cmd.op == i2csdb_pkg::OP_USER_RD) && i_cmd.last && r_ready)
        |=> (r_ack && !r_ready && r_ack_q))
        else $error("final user read did not release the buffer");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_tx_q) && $stable(r_rx_q)))
        else $error("result changed while stalled");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top - self-checking bench for the I2C slave double buffer
// Feeds TWI status events and user buffer accesses through the word input
// channel. An in-bench copy of the buffer state predicts every result word,
// and each result word is checked field by field against it, in order.
// ============================================================================
module tb_top;
    import i2csdb_pkg::*;

    // Item kind with no meaning to the block; it must give the plain result
    localparam logic [1:0] KIND_IGNORED  = 2'd3;
    // A status value that is not handled (masks to 0xF8)
    localparam logic [7:0] ST_UNHANDLED  = 8'hFF;

    localparam int STIM_WORDS    = 550;   // directed part plus random filler
    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES   = 8;     // settle time after the last result
    localparam int HOLD_CYCLES   = 60;    // long receiver hold-off
    localparam int HOLD_AT       = 320;   // results seen before the hold-off
    localparam int QUIET_FROM    = 150;   // window with no idling on either side
    localparam int QUIET_TO      = 260;

    // One input word and one result word, field for field
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] status;
        logic [7:0] bus_byte;
        logic [3:0] index;
        logic [7:0] user_byte;
        logic       last;
    } word_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       ack_enable;
        logic       data_ready;
        logic [7:0] read_byte;
    } result_t;

    // Buffer state, plus a mark per store entry that has been written
    typedef struct packed {
        logic [2*TX_DEPTH-1:0][7:0] tx_mem;
        logic [2*TX_DEPTH-1:0]      tx_wr;
        logic                       half;
        logic                       swap_req;
        logic                       upd_busy;
        t_tx_pos                    tx_pos;
        logic [RX_DEPTH-1:0][7:0]   rx_mem;
        logic [RX_DEPTH-1:0]        rx_wr;
        t_rx_pos                    rx_pos;
        logic                       ready;
        logic                       ack;
    } buf_state_t;

    localparam buf_state_t BUF_RESET = '{
        tx_mem: '0, tx_wr: '0, half: 1'b0, swap_req: 1'b0, upd_busy: 1'b0,
        tx_pos: '0, rx_mem: '0, rx_wr: '0, rx_pos: '0, ready: 1'b0, ack: 1'b1
    };

    // ------------------------------------------------------------------------
    // DUT ports, inputs known from time zero
    // ------------------------------------------------------------------------
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       o_ready;
    logic [1:0] i_kind        = '0;
    logic [7:0] i_status_code = '0;
    logic [7:0] i_bus_byte    = '0;
    logic [3:0] i_index       = '0;
    logic [7:0] i_user_byte   = '0;
    logic       i_last        = 1'b0;
    logic       o_valid;
    logic       i_ready       = 1'b0;
    logic [7:0] o_tx_byte;
    logic       o_ack_enable;
    logic       o_data_ready;
    logic [7:0] o_read_byte;

    i2c_slave_double_buffer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_status_code (i_status_code),
        .i_bus_byte    (i_bus_byte),
        .i_index       (i_index),
        .i_user_byte   (i_user_byte),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_tx_byte     (o_tx_byte),
        .o_ack_enable  (o_ack_enable),
        .o_data_ready  (o_data_ready),
        .o_read_byte   (o_read_byte)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    word_t      pending_words[$];   // words waiting to be offered
    result_t    due_results[$];     // predicted results, oldest first
    buf_state_t plan_state = BUF_RESET;  // state as the stimulus planner sees it
    buf_state_t live_state = BUF_RESET;  // state as of the last accepted word
    word_t      cur_word;           // word on the input port
    int         words_in     = 0;
    int         results_out  = 0;
    int         errors       = 0;
    int         n_bus        = 0;
    int         n_user_wr    = 0;
    int         n_user_rd    = 0;
    int         n_swaps      = 0;
    int         hold_left    = 0;
    bit         hold_done    = 1'b0;
    int         stall_cycles = 0;
    logic       half_before;
    result_t    want;

    // ------------------------------------------------------------------------
    // Predictor: applies one word to a buffer state, returns its result word
    // ------------------------------------------------------------------------
    function automatic result_t step_buffers(inout buf_state_t st, input word_t w);
        result_t    r;
        logic [7:0] code;
        int         p;
        bit         send;
        r          = '0;
        send       = 1'b0;
        r.data_ready = st.ready;   // flag as it was before this word
        case (w.kind)
            KIND_BUS: begin
                code = w.status & STATUS_MASK;
                case (code)
                    ST_ST_SLA_ACK, ST_ST_ARB_SLA: begin
                        // swap only once the user has finished the update
                        if (st.swap_req && !st.upd_busy) begin
                            st.half     = ~st.half;
                            st.swap_req = 1'b0;
                        end
                        st.tx_pos = '0;
                        send      = 1'b1;
                    end
                    ST_ST_DATA_ACK: send = 1'b1;
                    ST_ST_DATA_NACK, ST_ST_LAST_ACK, ST_BUS_ERROR: st.ack = 1'b1;
                    ST_SR_SLA_ACK, ST_SR_ARB_SLA, ST_SR_GCALL_ACK, ST_SR_ARB_GCALL: begin
                        st.ready  = 1'b0;
                        st.rx_pos = '0;
                        if (RX_DEPTH == 1) st.ack = 1'b0;
                    end
                    ST_SR_DATA_ACK, ST_SR_GDATA_ACK, ST_SR_DATA_NACK, ST_SR_GDATA_NACK: begin
                        // bytes beyond a full buffer are dropped
                        if (st.rx_pos < RX_DEPTH) begin
                            st.rx_mem[t_rx_idx'(st.rx_pos)] = w.bus_byte;
                            st.rx_wr[t_rx_idx'(st.rx_pos)]  = 1'b1;
                            st.rx_pos                       = st.rx_pos + 1'b1;
                        end
                        if (code == ST_SR_DATA_NACK || code == ST_SR_GDATA_NACK)
                            st.ready = 1'b1;
                        else if (st.rx_pos == RX_DEPTH - 1)
                            st.ack = 1'b0;   // NACK the byte that fills the buffer
                    end
                    ST_SR_STOP: st.ready = 1'b1;
                    default: ;
                endcase
                if (send) begin
                    // saturated position repeats the final byte
                    p = (st.tx_pos > TX_DEPTH - 1) ? TX_DEPTH - 1 : int'(st.tx_pos);
                    r.tx_byte = st.tx_mem[(st.half ? TX_DEPTH : 0) + p];
                    if (st.tx_pos < TX_DEPTH) st.tx_pos = st.tx_pos + 1'b1;
                    if (st.tx_pos == TX_DEPTH) st.ack = 1'b0;
                end
            end
            KIND_TX_WR: begin
                st.swap_req = 1'b1;
                st.upd_busy = !w.last;
                if (w.index < TX_DEPTH) begin
                    st.tx_mem[(st.half ? 0 : TX_DEPTH) + w.index] = w.user_byte;
                    st.tx_wr[(st.half ? 0 : TX_DEPTH) + w.index]  = 1'b1;
                end
            end
            KIND_RX_RD: begin
                if (w.index < RX_DEPTH) r.read_byte = st.rx_mem[w.index];
                if (w.last && st.ready) begin
                    st.ready = 1'b0;
                    st.ack   = 1'b1;
                end
            end
            default: ;
        endcase
        r.ack_enable = st.ack;
        return r;
    endfunction

    // A word is legal unless it would send or read a never-written entry
    function automatic bit word_is_legal(buf_state_t st, word_t w);
        logic [7:0] code;
        logic       half;
        int         p;
        code = w.status & STATUS_MASK;
        half = st.half;
        if (w.kind == KIND_RX_RD) return (w.index >= RX_DEPTH) || st.rx_wr[w.index];
        if (w.kind != KIND_BUS) return 1'b1;
        if (code == ST_ST_SLA_ACK || code == ST_ST_ARB_SLA) begin
            if (st.swap_req && !st.upd_busy) half = ~half;
            p = 0;
        end else if (code == ST_ST_DATA_ACK) begin
            p = (st.tx_pos > TX_DEPTH - 1) ? TX_DEPTH - 1 : int'(st.tx_pos);
        end else begin
            return 1'b1;
        end
        return st.tx_wr[(half ? TX_DEPTH : 0) + p];
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------------
    function automatic word_t rand_word();
        word_t w;
        w.kind      = 2'($urandom_range(0, 3));
        w.status    = 8'($urandom);
        w.bus_byte  = 8'($urandom);
        w.index     = 4'($urandom);
        w.user_byte = 8'($urandom);
        w.last      = 1'($urandom);
        return w;
    endfunction

    // random don't-care low bits on a status code
    function automatic logic [7:0] with_low(logic [7:0] code);
        return code | 8'($urandom_range(0, 7));
    endfunction

    // bursts are mostly short, now and then long enough to saturate
    function automatic int burst_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
    endfunction

    task automatic plan_word(input word_t w);
        result_t ignored;
        if (word_is_legal(plan_state, w)) begin
            ignored = step_buffers(plan_state, w);
            pending_words.push_back(w);
        end
    endtask

    task automatic plan_bus(input logic [7:0] code, input logic [7:0] data);
        word_t w;
        w          = rand_word();
        w.kind     = KIND_BUS;
        w.status   = code;
        w.bus_byte = data;
        plan_word(w);
    endtask

    // user rewrites the shadow half in shuffled order
    task automatic plan_update(input int count, input bit finish);
        int    order[TX_DEPTH];
        int    i, j, t;
        word_t w;
        for (i = 0; i < TX_DEPTH; i++) order[i] = i;
        for (i = TX_DEPTH - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (i = 0; i < count; i++) begin
            w       = rand_word();
            w.kind  = KIND_TX_WR;
            w.index = 4'(order[i]);
            w.last  = finish && (i == count - 1);
            plan_word(w);
        end
    endtask

    // master reads: address, data bytes, closing NACK or last-byte ack
    task automatic plan_master_read(input int count);
        int i;
        plan_bus(with_low($urandom_range(0, 1) ? ST_ST_SLA_ACK : ST_ST_ARB_SLA),
                 8'($urandom));
        for (i = 0; i < count; i++) plan_bus(with_low(ST_ST_DATA_ACK), 8'($urandom));
        plan_bus(with_low($urandom_range(0, 1) ? ST_ST_DATA_NACK : ST_ST_LAST_ACK),
                 8'($urandom));
    endtask

    // master writes: address, data bytes, then NACK and/or stop
    task automatic plan_master_write(input int count);
        logic [7:0] addr;
        int         i;
        int         tail;
        case ($urandom_range(0, 3))
            0:       addr = ST_SR_SLA_ACK;
            1:       addr = ST_SR_ARB_SLA;
            2:       addr = ST_SR_GCALL_ACK;
            default: addr = ST_SR_ARB_GCALL;
        endcase
        plan_bus(with_low(addr), 8'($urandom));
        for (i = 0; i < count; i++)
            plan_bus(with_low($urandom_range(0, 1) ? ST_SR_DATA_ACK : ST_SR_GDATA_ACK),
                     8'($urandom));
        tail = $urandom_range(0, 3);
        if (tail <= 1)
            plan_bus(with_low($urandom_range(0, 1) ? ST_SR_DATA_NACK : ST_SR_GDATA_NACK),
                     8'($urandom));
        if (tail >= 1) plan_bus(with_low(ST_SR_STOP), 8'($urandom));
    endtask

    // user collects the received message, sometimes without the closing read
    task automatic plan_collect();
        int    count;
        int    i;
        bit    close;
        word_t w;
        count = int'(plan_state.rx_pos);
        close = $urandom_range(0, 4) != 0;
        for (i = 0; i < count; i++) begin
            w       = rand_word();
            w.kind  = KIND_RX_RD;
            w.index = 4'(close ? i : $urandom_range(0, count - 1));
            w.last  = close && (i == count - 1);
            plan_word(w);
        end
    endtask

    function automatic bit idle_roll(bit quiet);
        return !quiet && ($urandom_range(0, 99) < 37);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers pending words, predicts each one at acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                half_before = live_state.half;
                due_results.push_back(step_buffers(live_state, cur_word));
                if (live_state.half != half_before) n_swaps = n_swaps + 1;
                case (cur_word.kind)
                    KIND_BUS:   n_bus     = n_bus + 1;
                    KIND_TX_WR: n_user_wr = n_user_wr + 1;
                    KIND_RX_RD: n_user_rd = n_user_rd + 1;
                    default: ;
                endcase
                words_in = words_in + 1;
            end
            // a held word stays put; otherwise maybe offer the next one
            if (!i_valid || o_ready) begin
                if (pending_words.size() != 0 &&
                    !idle_roll(words_in >= QUIET_FROM && words_in < QUIET_TO)) begin
                    cur_word = pending_words.pop_front();
                    i_valid       <= 1'b1;
                    i_kind        <= cur_word.kind;
                    i_status_code <= cur_word.status;
                    i_bus_byte    <= cur_word.bus_byte;
                    i_index       <= cur_word.index;
                    i_user_byte   <= cur_word.user_byte;
                    i_last        <= cur_word.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks result words in order, drives the receiver ready
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    $error("result word with nothing outstanding");
                    errors = errors + 1;
                end else begin
                    want = due_results.pop_front();
                    if (o_tx_byte !== want.tx_byte) begin
                        $error("tx_byte: expected %02h, got %02h", want.tx_byte, o_tx_byte);
                        errors = errors + 1;
                    end
                    if (o_ack_enable !== want.ack_enable) begin
                        $error("ack_enable: expected %0b, got %0b",
                               want.ack_enable, o_ack_enable);
                        errors = errors + 1;
                    end
                    if (o_data_ready !== want.data_ready) begin
                        $error("data_ready: expected %0b, got %0b",
                               want.data_ready, o_data_ready);
                        errors = errors + 1;
                    end
                    if (o_read_byte !== want.read_byte) begin
                        $error("read_byte: expected %02h, got %02h",
                               want.read_byte, o_read_byte);
                        errors = errors + 1;
                    end
                end
                results_out = results_out + 1;
            end
            // one long hold-off so the command queue fills and o_ready drops
            if (!hold_done && results_out >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !idle_roll(results_out >= QUIET_FROM && results_out < QUIET_TO);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any handshake ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: %0d cycles without a handshake", STALL_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        word_t w;
        int    i;

        // Directed: fill the shadow half with extreme bytes at both ends,
        // the closing write marks the update done
        for (i = TX_DEPTH - 1; i >= 0; i--) begin
            w           = rand_word();
            w.kind      = KIND_TX_WR;
            w.index     = 4'(i);
            w.user_byte = (i == 0) ? 8'h00 : (i == TX_DEPTH - 1) ? 8'hFF : w.user_byte;
            w.last      = (i == 0);
            plan_word(w);
        end
        plan_bus(ST_ST_SLA_ACK,   8'h00);   // read address: swap, send byte 0
        plan_bus(ST_ST_DATA_ACK,  8'hFF);   // next byte
        plan_bus(ST_ST_DATA_NACK, 8'h00);   // master ends the read
        plan_bus(ST_SR_SLA_ACK,   8'h00);   // write address
        plan_bus(ST_SR_DATA_ACK,  8'hFF);
        plan_bus(ST_SR_DATA_NACK, 8'h00);   // NACKed byte raises ready
        w       = rand_word();
        w.kind  = KIND_RX_RD;
        w.index = 0;
        w.last  = 1'b0;                     // read that leaves the flag set
        plan_word(w);
        w.index = 1;
        w.last  = 1'b1;                     // closing read clears it
        plan_word(w);
        plan_bus(ST_SR_STOP,   8'hFF);
        plan_bus(8'h07,        8'h00);      // masks to bus error
        plan_bus(ST_UNHANDLED, 8'hFF);      // unknown status
        w      = rand_word();
        w.kind = KIND_IGNORED;
        plan_word(w);

        // Random: mostly well-formed transfers with random content
        while (pending_words.size() < STIM_WORDS) begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                    plan_update(($urandom_range(0, 3) == 0) ? $urandom_range(1, TX_DEPTH)
                                                            : TX_DEPTH,
                                $urandom_range(0, 4) != 0);
                3, 4, 5, 6, 7, 8: plan_master_read(burst_len());
                9, 10, 11, 12, 13: plan_master_write(burst_len());
                14, 15, 16: plan_collect();
                default: plan_word(rand_word());   // noise
            endcase
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_valid) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d bus events, %0d shadow writes, %0d receive reads, %0d swaps",
                 n_bus, n_user_wr, n_user_rd, n_swaps);
        $display("%0d words in, %0d results checked, %0d mismatches",
                 words_in, results_out, errors);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
